[rtl/vmlf_pkg.sv]
// ----------------------------------------------------------------------------
// vmlf_pkg
// Shared widths, codes and types for the vertical median line filter.
// ----------------------------------------------------------------------------
package vmlf_pkg;

    // line store depth and the widths that follow from it
    localparam int MAX_ROW_WIDTH = 1024;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    localparam int CNT_W         = COL_W + 1;

    // fixed field widths
    localparam int PIX_W       = 8;
    localparam int HIST_TAPS   = 4;
    localparam int HIST_W      = PIX_W * HIST_TAPS;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int ROWS_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TAPS = 1'd1;

    // window size codes
    localparam logic TAPS_3 = 1'b0;
    localparam logic TAPS_5 = 1'b1;

    // rows of history needed before a window is complete
    localparam logic [ROWS_W-1:0] NEED_3   = 3'd2;
    localparam logic [ROWS_W-1:0] NEED_5   = 3'd4;
    localparam logic [ROWS_W-1:0] ROWS_MAX = 3'd4;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 11'd512;
    localparam logic             TAPS_RST      = TAPS_5;

    // line store access for one beat
    typedef struct packed {
        logic              rd_en;
        logic [COL_W-1:0]  rd_col;
        logic              wr_en;
        logic [COL_W-1:0]  wr_col;
        logic [HIST_W-1:0] wr_data;
    } t_store_req;

endpackage

[rtl/vmlf_line_store.sv]
// ----------------------------------------------------------------------------
// vmlf_line_store
// Column history memory: one write and one registered read per cycle, with
// bypass of a write that lands on the same column in the same cycle.
// ----------------------------------------------------------------------------
module vmlf_line_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vmlf_pkg::t_store_req         i_req,
    output logic [vmlf_pkg::HIST_W-1:0]  o_rd_data
);

    logic [vmlf_pkg::HIST_W-1:0] r_mem [vmlf_pkg::MAX_ROW_WIDTH];
    logic [vmlf_pkg::HIST_W-1:0] r_q;
    logic [vmlf_pkg::HIST_W-1:0] r_byp_data;
    logic                        r_byp;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_col] <= i_req.wr_data;
        end
    end

    // read port: hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_q        <= r_mem[i_req.rd_col];
            r_byp_data <= i_req.wr_data;
        end
    end

    // note a read that collides with a write in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_req.rd_en) begin
            r_byp <= i_req.wr_en && (i_req.wr_col == i_req.rd_col);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_q;

endmodule

[rtl/vmlf_median.sv]
// ----------------------------------------------------------------------------
// vmlf_median
// Median of the vertical window: three or five pixels by compare network.
// ----------------------------------------------------------------------------
module vmlf_median (
    input  logic [vmlf_pkg::PIX_W-1:0]  i_pixel,
    input  logic [vmlf_pkg::HIST_W-1:0] i_hist,
    input  logic                        i_taps,
    output logic [vmlf_pkg::PIX_W-1:0]  o_median
);

    function automatic logic [vmlf_pkg::PIX_W-1:0] f_min(
        input logic [vmlf_pkg::PIX_W-1:0] a,
        input logic [vmlf_pkg::PIX_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic [vmlf_pkg::PIX_W-1:0] f_max(
        input logic [vmlf_pkg::PIX_W-1:0] a,
        input logic [vmlf_pkg::PIX_W-1:0] b
    );
        return (a < b) ? b : a;
    endfunction

    function automatic logic [vmlf_pkg::PIX_W-1:0] f_med3(
        input logic [vmlf_pkg::PIX_W-1:0] a,
        input logic [vmlf_pkg::PIX_W-1:0] b,
        input logic [vmlf_pkg::PIX_W-1:0] c
    );
        return f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

    logic [vmlf_pkg::PIX_W-1:0] h0, h1, h2, h3;
    logic [vmlf_pkg::PIX_W-1:0] lo_pair, hi_pair;
    logic [vmlf_pkg::PIX_W-1:0] med_3, med_5;

    assign h0 = i_hist[0*vmlf_pkg::PIX_W +: vmlf_pkg::PIX_W];
    assign h1 = i_hist[1*vmlf_pkg::PIX_W +: vmlf_pkg::PIX_W];
    assign h2 = i_hist[2*vmlf_pkg::PIX_W +: vmlf_pkg::PIX_W];
    assign h3 = i_hist[3*vmlf_pkg::PIX_W +: vmlf_pkg::PIX_W];

    // drop the overall minimum and maximum of the four history pixels' pairs,
    // then take the median of what is left with the current pixel
    assign lo_pair = f_max(f_min(h0, h1), f_min(h2, h3));
    assign hi_pair = f_min(f_max(h0, h1), f_max(h2, h3));
    assign med_5   = f_med3(i_pixel, lo_pair, hi_pair);
    assign med_3   = f_med3(i_pixel, h0, h1);

    assign o_median = (i_taps == vmlf_pkg::TAPS_5) ? med_5 : med_3;

endmodule

[rtl/vertical_median_line_filter_unit.sv]
// ----------------------------------------------------------------------------
// vertical_median_line_filter_unit
// Column median filter over a raster pixel stream, 3 or 5 taps.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock and gives one result per clock once the first
// rows of a frame are in, while the output does not stall; each result passes
// through the pixel stage and the result register. The rate is set by the line
// store, which does one registered read when a pixel is taken and one write of
// the updated column history as the stage moves on; a same-column write and
// read in one cycle (narrow rows) is bypassed. The store needs no clearing pass
// after reset. Each result is the median of the column's window and belongs to
// the newest row of that window, so the first two (3-tap) or four (5-tap) rows
// of a frame give no result. Assert i_start_of_frame on the first pixel of
// each frame. Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module vertical_median_line_filter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vmlf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vmlf_pkg::CFG_W-1:0]     i_cfg_data,
    // pixel input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [vmlf_pkg::PIX_W-1:0]     i_pixel,
    input  logic                           i_start_of_frame,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [vmlf_pkg::PIX_W-1:0]     o_median,
    output logic                           o_end_of_row
);

    // configuration registers
    logic [vmlf_pkg::CFG_W-1:0]  r_row_width;
    logic                        r_taps;

    // frame position
    logic [vmlf_pkg::COL_W-1:0]  r_col_idx, n_col_idx;
    logic [vmlf_pkg::ROWS_W-1:0] r_rows, n_rows;

    // pixel stage
    logic                        r_a_valid;
    logic [vmlf_pkg::PIX_W-1:0]  r_a_pixel;
    logic [vmlf_pkg::COL_W-1:0]  r_a_col;
    logic                        r_a_emit;
    logic                        r_a_last;

    // result register
    logic                        r_out_valid;
    logic [vmlf_pkg::PIX_W-1:0]  r_median;
    logic                        r_eor;

    logic                        in_take;
    logic                        a_fire;
    logic                        out_free;
    logic [vmlf_pkg::CNT_W-1:0]  eff_width;
    logic [vmlf_pkg::COL_W-1:0]  cur_col;
    logic [vmlf_pkg::ROWS_W-1:0] cur_rows;
    logic [vmlf_pkg::ROWS_W-1:0] need_rows;
    logic                        cur_last;
    logic [vmlf_pkg::HIST_W-1:0] hist;
    logic [vmlf_pkg::PIX_W-1:0]  a_median;
    vmlf_pkg::t_store_req        store_req;

    // configuration port is always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= vmlf_pkg::ROW_WIDTH_RST;
            r_taps      <= vmlf_pkg::TAPS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vmlf_pkg::REG_ROW_WIDTH:   r_row_width <= i_cfg_data;
                vmlf_pkg::REG_WINDOW_TAPS: r_taps      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the row width into one to the line store depth
    always_comb begin
        if (r_row_width == '0) begin
            eff_width = vmlf_pkg::CNT_W'(1);
        end else if (32'(r_row_width) > 32'(vmlf_pkg::MAX_ROW_WIDTH)) begin
            eff_width = vmlf_pkg::CNT_W'(vmlf_pkg::MAX_ROW_WIDTH);
        end else begin
            eff_width = vmlf_pkg::CNT_W'(r_row_width);
        end
    end

    // handshake: the pixel stage moves on when it has no result or room for it
    assign out_free   = !r_out_valid || !i_out_stall;
    assign a_fire     = r_a_valid && (!r_a_emit || out_free);
    assign o_in_stall = r_a_valid && !a_fire;
    assign in_take    = i_in_valid && !o_in_stall;

    // position of the incoming beat; start of frame clears the counters
    assign cur_col   = i_start_of_frame ? '0 : r_col_idx;
    assign cur_rows  = i_start_of_frame ? '0 : r_rows;
    assign cur_last  = ({1'b0, cur_col} + vmlf_pkg::CNT_W'(1)) >= eff_width;
    assign need_rows = (r_taps == vmlf_pkg::TAPS_5) ? vmlf_pkg::NEED_5 : vmlf_pkg::NEED_3;

    // advance the column and saturating row counters
    always_comb begin
        n_col_idx = r_col_idx;
        n_rows    = r_rows;
        if (in_take) begin
            if (cur_last) begin
                n_col_idx = '0;
                n_rows    = (cur_rows < vmlf_pkg::ROWS_MAX) ?
                            cur_rows + vmlf_pkg::ROWS_W'(1) : cur_rows;
            end else begin
                n_col_idx = cur_col + vmlf_pkg::COL_W'(1);
                n_rows    = cur_rows;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_idx <= '0;
            r_rows    <= '0;
        end else begin
            r_col_idx <= n_col_idx;
            r_rows    <= n_rows;
        end
    end

    // pixel stage: hold the beat through the line store read and any stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_pixel <= i_pixel;
            r_a_col   <= cur_col;
            r_a_emit  <= cur_rows >= need_rows;
            r_a_last  <= cur_last;
        end
    end

    // read the column on take, write the shifted history as the stage moves on
    assign store_req.rd_en   = in_take;
    assign store_req.rd_col  = cur_col;
    assign store_req.wr_en   = a_fire;
    assign store_req.wr_col  = r_a_col;
    assign store_req.wr_data = {hist[vmlf_pkg::HIST_W-vmlf_pkg::PIX_W-1:0], r_a_pixel};

    vmlf_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (hist)
    );

    vmlf_median u_median (
        .i_pixel  (r_a_pixel),
        .i_hist   (hist),
        .i_taps   (r_taps),
        .o_median (a_median)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= a_fire && r_a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && a_fire && r_a_emit) begin
            r_median <= a_median;
            r_eor    <= r_a_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_median     = r_median;
    assign o_end_of_row = r_eor;

    // the input stalls only behind a held pixel beat
    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_valid
    ) else $error("input stalled with an empty pixel stage");

    // a held pixel beat keeps its column
    a_stage_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_fire) |=> (r_a_valid && $stable(r_a_col) && $stable(r_a_emit))
    ) else $error("pixel stage changed while held");

    // a completed window always reaches the result register
    a_result_lands: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && r_a_emit) |=> o_out_valid
    ) else $error("completed window lost");

    // row count saturates
    a_rows_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= vmlf_pkg::ROWS_MAX
    ) else $error("row count beyond saturation");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertical median line filter unit.
// ----------------------------------------------------------------------------
// A queue of pending pixels feeds a clocked driver; a clocked monitor applies
// random back-pressure on the result side. Every accepted pixel goes through
// a local column-median predictor, and each accepted result is checked field
// by field against the oldest predicted median. Stimulus covers a zero-width
// row, a short row with a restart part-way, an oversized row, a row width
// cut down in the middle of a frame, a window size switched in the middle of
// a frame, and many random frames of small widths with stray frame starts.
// ----------------------------------------------------------------------------
module tb_top;
    import vmlf_pkg::*;

    // bench limits
    localparam int CLK_HALF     = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RAND_ITEMS   = 450;
    localparam int MAX_REPORTS  = 40;

    // pixel content styles for random frames
    localparam int PIX_FLAT  = 0;
    localparam int PIX_RAIL  = 1;
    localparam int PIX_BAND  = 2;
    localparam int PIX_SPIKE = 3;

    // directed pixel runs, byte 0 at the right
    localparam logic [79:0]  SEQ_WIDTH0 = {8'd254, 8'd1, 8'd0, 8'd0, 8'd255,
                                           8'd128, 8'd0, 8'd255, 8'd255, 8'd0};
    localparam logic [103:0] SEQ_SHORT  = {8'd200, 8'd0, 8'd0, 8'd0, 8'd255,
                                           8'd128, 8'd128, 8'd34, 8'd255,
                                           8'd0, 8'd17, 8'd0, 8'd255};

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             sof;
    } t_pixel_beat;

    typedef struct {
        logic [PIX_W-1:0] median;
        logic             end_of_row;
    } t_median_beat;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [CFG_W-1:0]     i_cfg_data       = '0;
    logic                 i_in_valid       = 1'b0;
    logic [PIX_W-1:0]     i_pixel          = '0;
    logic                 i_start_of_frame = 1'b0;
    logic                 i_out_stall      = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [PIX_W-1:0]     o_median;
    logic                 o_end_of_row;

    // handshake outcomes of the last rising edge
    logic cfg_fired = 1'b0;
    logic in_fired  = 1'b0;
    logic out_fired = 1'b0;

    t_pixel_beat  pixel_q[$];
    t_median_beat median_q[$];

    // predictor state
    logic [HIST_W-1:0] col_hist [MAX_ROW_WIDTH];
    int                col_pos       = 0;
    int                rows_done     = 0;
    logic [CFG_W-1:0]  cfg_row_width = ROW_WIDTH_RST;
    logic              cfg_taps      = TAPS_RST;

    // run bookkeeping
    bit idle_on        = 1'b1;
    int send_wait      = 0;
    int hold_left      = 0;
    int pushed_count   = 0;
    int pixels_taken   = 0;
    int medians_seen   = 0;
    int err_count      = 0;
    int quiet_cycles   = 0;
    int phase_count    = 0;

    vertical_median_line_filter_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pixel          (i_pixel),
        .i_start_of_frame (i_start_of_frame),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_median         (o_median),
        .o_end_of_row     (o_end_of_row)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // clamp the programmed width to what the line store can hold
    function automatic int eff_width(input logic [CFG_W-1:0] w);
        if (w == 0) begin
            return 1;
        end
        if (int'(w) > MAX_ROW_WIDTH) begin
            return MAX_ROW_WIDTH;
        end
        return int'(w);
    endfunction

    // advance the column model by one pixel and queue its median, if any
    function automatic void filter_column(input logic [PIX_W-1:0] pix, input logic sof);
        int                width;
        int                need;
        int                n;
        int                i;
        int                j;
        logic [HIST_W-1:0] hist;
        logic [PIX_W-1:0]  win [5];
        logic [PIX_W-1:0]  t;
        logic              last;
        t_median_beat      beat;
        width = eff_width(cfg_row_width);
        need  = (cfg_taps == TAPS_5) ? int'(NEED_5) : int'(NEED_3);
        if (sof) begin
            col_pos   = 0;
            rows_done = 0;
        end
        hist = col_hist[col_pos];
        last = (col_pos + 1 >= width);
        if (rows_done >= need) begin
            n      = need + 1;
            win[0] = pix;
            for (i = 0; i < need; i++) begin
                win[i + 1] = hist[PIX_W*i +: PIX_W];
            end
            // insertion sort over the window
            for (i = 1; i < n; i++) begin
                t = win[i];
                j = i;
                while (j > 0 && win[j - 1] > t) begin
                    win[j] = win[j - 1];
                    j--;
                end
                win[j] = t;
            end
            beat.median     = win[n / 2];
            beat.end_of_row = last;
            median_q.push_back(beat);
        end
        col_hist[col_pos] = {hist[HIST_W-PIX_W-1:0], pix};
        if (last) begin
            col_pos = 0;
            if (rows_done < int'(ROWS_MAX)) begin
                rows_done++;
            end
        end else begin
            col_pos++;
        end
    endfunction

    function automatic logic [PIX_W-1:0] draw_pixel(input int style, input int base);
        int v;
        case (style)
            PIX_RAIL: begin
                return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end
            PIX_BAND: begin
                v = base + int'($urandom_range(0, 8)) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return v[PIX_W-1:0];
            end
            PIX_SPIKE: begin
                if ($urandom_range(0, 5) == 0) begin
                    return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                end
                return base[PIX_W-1:0];
            end
            default: begin
                return PIX_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // observe every handshake at the rising edge
    always @(posedge i_clk) begin
        t_median_beat want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_ROW_WIDTH) begin
                    cfg_row_width = i_cfg_data;
                end else if (i_cfg_index == REG_WINDOW_TAPS) begin
                    cfg_taps = i_cfg_data[0];
                end
            end
            // check the result beat before the new pixel is predicted
            if (o_out_valid && !i_out_stall) begin
                medians_seen++;
                if (median_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $error("unexpected result: median %0d end_of_row %0d",
                               o_median, o_end_of_row);
                    end
                end else begin
                    want = median_q.pop_front();
                    if (o_median !== want.median) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $error("median: expected %0d, actual %0d",
                                   want.median, o_median);
                        end
                    end
                    if (o_end_of_row !== want.end_of_row) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $error("end_of_row: expected %0d, actual %0d",
                                   want.end_of_row, o_end_of_row);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                filter_column(i_pixel, i_start_of_frame);
                pixels_taken++;
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        cfg_fired <= i_rst_n && i_cfg_valid && o_cfg_ready;
        in_fired  <= i_rst_n && i_in_valid && !o_in_stall;
        out_fired <= i_rst_n && o_out_valid && !i_out_stall;
    end

    // pixel driver: hold a stalled beat, otherwise wait out the gap and send
    always @(negedge i_clk) begin
        t_pixel_beat beat;
        if (!(i_in_valid && !in_fired)) begin
            if (send_wait != 0) begin
                send_wait--;
                i_in_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                beat = pixel_q.pop_front();
                i_pixel          <= beat.pixel;
                i_start_of_frame <= beat.sof;
                i_in_valid       <= 1'b1;
                send_wait = idle_on ? int'($urandom_range(0, 18)) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor: stall each result for a drawn number of cycles
    always @(negedge i_clk) begin
        if (out_fired) begin
            hold_left = idle_on ? int'($urandom_range(0, 18)) : 0;
        end
        if (o_out_valid && hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any beat
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("vertical_median_line_filter_unit verification failed");
        $finish;
    end

    // wait until every queued pixel is taken and every median has come back
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pixels_taken != pushed_count || median_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do begin
            @(negedge i_clk);
        end while (!cfg_fired);
    endtask

    // program both registers once the block has gone idle
    task automatic set_up(input logic [CFG_W-1:0] width, input logic taps);
        wait_idle();
        write_reg(REG_ROW_WIDTH, width);
        write_reg(REG_WINDOW_TAPS, {{(CFG_W-1){1'b0}}, taps});
        i_cfg_valid <= 1'b0;
        phase_count++;
    endtask

    task automatic queue_pixel(input logic [PIX_W-1:0] pix, input logic sof);
        t_pixel_beat beat;
        beat.pixel = pix;
        beat.sof   = sof;
        pixel_q.push_back(beat);
        pushed_count++;
    endtask

    initial begin
        int               i;
        int               pick;
        int               width_now;
        int               frame_min;
        int               rows;
        int               nitems;
        int               style;
        int               base;
        int               rand_items;
        bit               fresh;
        logic [CFG_W-1:0] width_cfg;
        logic [CFG_W-1:0] prev_width;
        logic             taps;
        rand_items = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero width acts as one pixel per row
        set_up(11'd0, TAPS_5);
        for (i = 0; i < 10; i++) begin
            queue_pixel(SEQ_WIDTH0[8*i +: 8], i == 0);
        end

        // short rows, 3 taps, with a frame restart part-way
        set_up(11'd3, TAPS_3);
        for (i = 0; i < 13; i++) begin
            queue_pixel(SEQ_SHORT[8*i +: 8], i == 0 || i == 9);
        end

        // oversized width at full rate, stop part-way through the second row
        set_up(11'd2047, TAPS_3);
        idle_on = 1'b0;
        for (i = 0; i < MAX_ROW_WIDTH + 150; i++) begin
            queue_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
        end

        // cut the width below the current column without a new frame
        set_up(11'd37, TAPS_3);
        idle_on = 1'b1;
        for (i = 0; i < 3 * 37 + 10; i++) begin
            queue_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
        end

        // switch to 5 taps in the middle of the same frame
        set_up(11'd37, TAPS_5);
        for (i = 0; i < 2 * 37 + 5; i++) begin
            queue_pixel(draw_pixel(PIX_BAND, 120), 1'b0);
        end
        frame_min  = 37;
        prev_width = 11'd37;

        // random frames, mostly well formed, with stray frame starts
        while (rand_items < RAND_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                width_cfg = CFG_W'($urandom_range(0, 1));
            end else if (pick <= 6) begin
                width_cfg = CFG_W'($urandom_range(2, 40));
            end else if (pick <= 8) begin
                width_cfg = CFG_W'($urandom_range(41, 128));
            end else begin
                width_cfg = prev_width;
            end
            taps      = ($urandom_range(0, 1) != 0);
            width_now = eff_width(width_cfg);
            // carry on the frame only where no column can be read unwritten
            fresh = !(width_now <= frame_min && $urandom_range(0, 2) == 0);
            if (fresh) begin
                frame_min = width_now;
            end
            rows   = ((taps == TAPS_5) ? int'(NEED_5) : int'(NEED_3)) + 1 +
                     ((width_now <= 40) ? int'($urandom_range(0, 4)) : 0);
            nitems = rows * width_now + int'($urandom_range(0, width_now - 1));
            style  = $urandom_range(PIX_FLAT, PIX_SPIKE);
            base   = $urandom_range(0, 255);
            idle_on = ($urandom_range(0, 3) != 0);
            set_up(width_cfg, taps);
            for (i = 0; i < nitems; i++) begin
                queue_pixel(draw_pixel(style, base),
                            (i == 0 && fresh) || $urandom_range(0, 149) == 0);
            end
            rand_items += nitems;
            prev_width = width_cfg;
        end

        wait_idle();
        if (median_q.size() != 0) begin
            err_count++;
            $error("%0d medians never arrived", median_q.size());
        end
        $display("Covered %0d pixels over %0d register settings, %0d medians checked.",
                 pixels_taken, phase_count, medians_seen);
        $display("Widths 0 to 2047, both window sizes, mid-frame width and tap changes.");
        if (err_count == 0) begin
            $display("vertical_median_line_filter_unit verification clean");
        end else begin
            $display("vertical_median_line_filter_unit verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/vmlf_pkg.sv
rtl/vmlf_line_store.sv
rtl/vmlf_median.sv
rtl/vertical_median_line_filter_unit.sv
verif/tb_top.sv
